[rtl/lrrg_pkg.sv]
// Package for the Lehmer random range generator.
// Holds the operation codes and the fixed arithmetic constants; no dependencies.
package lrrg_pkg;

  // Operation codes carried on the opcode field.
  localparam logic [1:0] OP_RESEED   = 2'd0;
  localparam logic [1:0] OP_FRACTION = 2'd1;
  localparam logic [1:0] OP_INTEGER  = 2'd2;
  localparam logic [1:0] OP_COIN     = 2'd3;

  // Modulus 2^31-1 and the minimal-standard multiplier.
  localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [31:0] LCG_MUL = 32'd48271;

  // Half of (M-1): the divisor 2^30-1 after the common factor of two is taken out.
  localparam logic [29:0] DIV_D = 30'h3FFF_FFFF;

  // One half in Q0.31.
  localparam logic [30:0] HALF_Q31 = 31'h4000_0000;

endpackage

[rtl/lehmer_random_range_generator.sv]
// Lehmer random range generator, top level and only module.
// Depends on lrrg_pkg for operation codes and arithmetic constants.
//
// Usage: a request enters on in_valid/in_stall and is taken at a clock edge
// with in_valid high and in_stall low. The opcode selects reseed, fraction,
// bounded integer or coin. Each request yields exactly one result on
// out_valid/out_stall, held in an output register until the receiver takes it.
// A single 31x32 multiplier is reused under a small sequencer,
// so the block works on one request at a time and raises in_stall meanwhile.
// From acceptance to the result register, a reseed passes through the seed
// and done states; fraction and coin draws add the multiply and reduce states
// in between. The integer draw adds a second pass through the multiplier and
// the divide-by-(2^30-1) folding loop, which sets the worst case. The next
// request is taken in the cycle after the result is loaded. A new request
// is taken as soon as the previous result sits in the output register, even
// while the receiver stalls it; the next result then waits in the sequencer
// until the output register frees up. Reset clears the generator state to
// zero, which means unseeded: the next draw seeds itself from the entropy
// field.
module lehmer_random_range_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] seed_value,
  input  logic [31:0] entropy,
  input  logic [31:0] bound_a,
  input  logic [31:0] bound_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] state_out,
  output logic [30:0] fraction,
  output logic [31:0] int_result,
  output logic        coin
);
  import lrrg_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_RED  = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state;
  logic [30:0] gen_state;

  // Captured request.
  logic [1:0]  op;
  logic [31:0] seed;
  logic [31:0] ent;
  logic [31:0] bnd_a;
  logic [31:0] bnd_b;

  // Working registers.
  logic [30:0] t;      // state being advanced, then t-1
  logic [31:0] lo;     // smaller bound
  logic [32:0] span;   // hi - lo + 1, up to 2^32
  logic [62:0] prod;   // registered multiplier result
  logic [61:0] x;      // dividend being folded
  logic [32:0] q;      // running quotient
  logic [30:0] frac;
  logic [31:0] ires;

  // Reseed: reduce the signed seed into [0, M-1].
  logic [32:0] seed_plus_m;
  logic [30:0] reseed_val;
  always_comb begin
    seed_plus_m = {seed[31], seed} + {2'b00, LCG_MOD};
    if (!seed[31]) begin
      reseed_val = (seed[30:0] == LCG_MOD) ? 31'd0 : seed[30:0];
    end else if (seed_plus_m[32]) begin
      // Only the most negative seed lands here: it needs a second M.
      reseed_val = LCG_MOD - 31'd1;
    end else begin
      reseed_val = seed_plus_m[30:0];
    end
  end

  // Entropy mod M: fold bit 31 onto the low 31 bits, then one subtract.
  logic [31:0] ent_fold;
  logic [30:0] ent_mod;
  always_comb begin
    ent_fold = {31'd0, ent[31]} + {1'b0, ent[30:0]};
    if (ent_fold >= {1'b0, LCG_MOD}) begin
      ent_mod = 31'(ent_fold - {1'b0, LCG_MOD});
    end else begin
      ent_mod = ent_fold[30:0];
    end
  end

  // Bound ordering and span.
  logic        a_lt_b;
  logic [31:0] lo_sel;
  logic [31:0] hi_sel;
  logic [32:0] span_calc;
  always_comb begin
    a_lt_b    = $signed(bnd_a) < $signed(bnd_b);
    lo_sel    = a_lt_b ? bnd_a : bnd_b;
    hi_sel    = a_lt_b ? bnd_b : bnd_a;
    span_calc = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel} + 33'd1;
  end

  // Shared multiplier.
  logic [30:0] mul_a;
  logic [31:0] mul_b;
  logic [62:0] mul_p;
  always_comb begin
    mul_a = t;
    mul_b = (state == S_MUL2) ? span[31:0] : LCG_MUL;
    mul_p = 63'(mul_a) * 63'(mul_b);
  end

  // Mersenne reduction of t*48271 (below 2^47).
  logic [31:0] red_sum;
  logic [30:0] t_new;
  logic [30:0] tm1;
  always_comb begin
    red_sum = {16'd0, prod[46:31]} + {1'b0, prod[30:0]};
    if (red_sum >= {1'b0, LCG_MOD}) begin
      t_new = 31'(red_sum - {1'b0, LCG_MOD});
    end else begin
      t_new = red_sum[30:0];
    end
    tm1 = (t_new == 31'd0) ? 31'd0 : t_new - 31'd1;
  end

  // Division by 2^30-1: x = h*2^30 + l = h*D + (h + l), so fold until h is zero.
  logic [31:0] x_hi;
  logic [29:0] x_lo;
  logic [32:0] off;
  always_comb begin
    x_hi = x[61:30];
    x_lo = x[29:0];
    off  = q + {32'd0, (x_lo == DIV_D)};
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen_state <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded now.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            seed  <= seed_value;
            ent   <= entropy;
            bnd_a <= bound_a;
            bnd_b <= bound_b;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          lo   <= lo_sel;
          span <= span_calc;
          ires <= '0;
          if (op == OP_RESEED) begin
            gen_state <= reseed_val;
            frac      <= '0;
            state     <= S_DONE;
          end else begin
            t     <= (gen_state == 31'd0) ? ent_mod : gen_state;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_RED;
        end
        S_RED: begin
          gen_state <= t_new;
          t         <= tm1;
          // (t-1)*2^31/(M-1) = (t-1) + floor((t-1)/(2^30-1)), which is 0 or 1.
          frac      <= tm1 + {30'd0, (tm1 >= {1'b0, DIV_D})};
          state     <= (op == OP_INTEGER) ? S_MUL2 : S_DONE;
        end
        S_MUL2: begin
          // A span of exactly 2^32 is a shift rather than a multiply.
          if (span[32]) begin
            x <= {t, 31'd0};
          end else begin
            x <= mul_p[62:1];
          end
          q     <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (x_hi != 32'd0) begin
            q <= q + {1'b0, x_hi};
            x <= {30'd0, x_hi} + {32'd0, x_lo};
          end else begin
            ires  <= lo + off[31:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_out  <= gen_state;
            fraction   <= frac;
            int_result <= ires;
            coin       <= (op == OP_COIN) && (frac < HALF_Q31);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb_lehmer_random_range_generator.sv]
// Testbench for the Lehmer random range generator: directed and random requests checked
// against a cycle-free predictor kept in a small scoreboard class.
// Depends on lrrg_pkg and the lehmer_random_range_generator RTL only.
module tb_lehmer_random_range_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import lrrg_pkg::*;

  // Arithmetic constants in 64-bit signed form for the predictor.
  // Every intermediate product stays below 2^63.
  localparam longint MOD_L  = 64'sd2147483647;
  localparam longint MUL_L  = 64'sd48271;
  localparam longint HALF_L = 64'sd1073741824;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int STEADY_TAIL     = 200;   // last requests run with no idling on either side
  localparam int QUIET_LIMIT     = 2000;  // cycles without any handshake before giving up
  localparam int MAX_PRINTED     = 60;

  // One result as the block presents it, in port order.
  typedef struct packed {
    logic [30:0] state_out;
    logic [30:0] fraction;
    logic [31:0] int_result;
    logic        coin;
  } lcg_result_t;

  // Holds a private copy of the generator state and the results still owed by the block.
  class lcg_scoreboard;
    logic [30:0] gen_state;
    lcg_result_t awaited_q[$];
    int          mismatches;
    int          results_seen;

    function new();
      gen_state    = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending_count();
      return awaited_q.size();
    endfunction

    // Applies one request to the generator and returns the result it must produce.
    function lcg_result_t step_generator(logic [1:0] op, logic [31:0] seed, logic [31:0] ent,
                                         logic [31:0] ba, logic [31:0] bb);
      lcg_result_t r;
      longint      s, t, tm1, q, lo, hi, off;
      r = '0;
      if (op == OP_RESEED) begin
        // Signed seed folded into [0, M-1]; a multiple of M leaves the state unseeded.
        s = longint'($signed(seed));
        s = s % MOD_L;
        if (s < 0) s += MOD_L;
        gen_state   = s[30:0];
        r.state_out = gen_state;
        return r;
      end
      t = longint'({33'd0, gen_state});
      if (t == 0) t = longint'({32'd0, ent}) % MOD_L;
      t = (t * MUL_L) % MOD_L;
      gen_state   = t[30:0];
      tm1         = (t == 0) ? 64'sd0 : t - 1;
      q           = (tm1 << 31) / (MOD_L - 1);
      r.state_out = gen_state;
      r.fraction  = q[30:0];
      if (op == OP_INTEGER) begin
        lo = longint'($signed(ba));
        hi = longint'($signed(bb));
        if (hi < lo) begin
          lo = longint'($signed(bb));
          hi = longint'($signed(ba));
        end
        off          = (tm1 * (hi - lo + 1)) / (MOD_L - 1);
        lo           = lo + off;
        r.int_result = lo[31:0];
      end else if (op == OP_COIN) begin
        r.coin = (q < HALF_L);
      end
      return r;
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] seed, logic [31:0] ent,
                               logic [31:0] ba, logic [31:0] bb);
      awaited_q.push_back(step_generator(op, seed, ent, ba, bb));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    task check_result(lcg_result_t got);
      lcg_result_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = awaited_q.pop_front();
      if (got.state_out !== want.state_out)
        report_mismatch($sformatf("state_out got %h want %h", got.state_out, want.state_out));
      if (got.fraction !== want.fraction)
        report_mismatch($sformatf("fraction got %h want %h", got.fraction, want.fraction));
      if (got.int_result !== want.int_result)
        report_mismatch($sformatf("int_result got %h want %h", got.int_result, want.int_result));
      if (got.coin !== want.coin)
        report_mismatch($sformatf("coin got %b want %b", got.coin, want.coin));
    endtask
  endclass

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode     = OP_RESEED;
  logic [31:0] seed_value = '0;
  logic [31:0] entropy    = '0;
  logic [31:0] bound_a    = '0;
  logic [31:0] bound_b    = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [30:0] state_out;
  logic [30:0] fraction;
  logic [31:0] int_result;
  logic        coin;

  lcg_scoreboard sb;
  int            quiet_cycles = 0;
  bit            steady_tail  = 1'b0;

  lehmer_random_range_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .seed_value (seed_value),
    .entropy    (entropy),
    .bound_a    (bound_a),
    .bound_b    (bound_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .state_out  (state_out),
    .fraction   (fraction),
    .int_result (int_result),
    .coin       (coin)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor. All drives happen through nonblocking assignments at the
  // rising edge, so the values read here are the ones the block saw at this edge.
  // The result is checked before the new request is noted, so a stray result can
  // never be matched against the request taken in the same cycle.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result({state_out, fraction, int_result, coin});
      if (in_valid && !in_stall)
        sb.note_request(opcode, seed_value, entropy, bound_a, bound_b);
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Receiver backpressure: stall bursts of random length separated by free
  // stretches of random length. The stall always drops between bursts,
  // and stays low during the steady tail of the run.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  // Sends one request, sometimes after an idle burst, and returns at the edge
  // where the block takes it. Valid stays high on return so back-to-back
  // requests are never lowered and raised in the same step.
  task automatic issue_request(logic [1:0] op, logic [31:0] seed, logic [31:0] ent,
                               logic [31:0] ba, logic [31:0] bb);
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    seed_value <= seed;
    entropy    <= ent;
    bound_a    <= ba;
    bound_b    <= bb;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the sender until the block has returned every result owed. The first
  // edge lets the monitor record a request taken at the current edge.
  task automatic wait_for_results();
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // Bounds and seeds: the signed extremes, values near zero, or anything.
  function automatic logic [31:0] pick_signed_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h8000_0001;
          4:       return 32'h7FFF_FFFE;
          default: return 32'h0000_0000;
        endcase
      end
      1:       return $urandom_range(0, 20) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [1:0]  op;
    logic [31:0] seed, ent, ba, bb;
    int          n;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The generator starts unseeded, so the first draws take
    // their seed from the entropy field; entropy of 0, M and 2M leaves the state
    // at zero, which yields a zero fraction, the low bound and a coin of one.
    issue_request(OP_FRACTION, 32'h0,         32'h0000_0000, 32'h0,         32'h0);
    issue_request(OP_INTEGER,  32'h0,         32'h7FFF_FFFF, 32'd5,         -32'sd3);
    issue_request(OP_COIN,     32'h0,         32'hFFFF_FFFE, 32'h0,         32'h0);
    issue_request(OP_FRACTION, 32'h0,         32'hFFFF_FFFF, 32'h0,         32'h0);
    // A zero seed returns the generator to the unseeded state.
    issue_request(OP_RESEED,   32'h0,         32'h0,         32'h0,         32'h0);
    issue_request(OP_COIN,     32'h0,         32'h1234_5678, 32'h0,         32'h0);
    // Seed equal to M also folds to zero; then the full signed span.
    issue_request(OP_RESEED,   32'h7FFF_FFFF, 32'h0,         32'h0,         32'h0);
    issue_request(OP_INTEGER,  32'h0,         32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    // Most negative seed folds to M-1; reversed full-span bounds are swapped.
    issue_request(OP_RESEED,   32'h8000_0000, 32'h0,         32'h0,         32'h0);
    issue_request(OP_INTEGER,  32'h0,         32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    issue_request(OP_RESEED,   32'hFFFF_FFFF, 32'h0,         32'h0,         32'h0);
    issue_request(OP_FRACTION, 32'h0,         32'h0,         32'h0,         32'h0);
    issue_request(OP_RESEED,   32'h0000_0001, 32'h0,         32'h0,         32'h0);
    // Equal bounds must return that bound, at both extremes.
    issue_request(OP_INTEGER,  32'h0,         32'h0,         32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue_request(OP_INTEGER,  32'h0,         32'h0,         32'h8000_0000, 32'h8000_0000);
    issue_request(OP_COIN,     32'h0,         32'h0,         32'h0,         32'h0);
    // State M-1 gives a fraction close to the top of the range.
    issue_request(OP_RESEED,   32'h7FFF_FFFE, 32'h0,         32'h0,         32'h0);
    issue_request(OP_FRACTION, 32'h0,         32'h0,         32'h0,         32'h0);
    issue_request(OP_INTEGER,  32'h0,         32'h0,         32'h0,         32'h0);
    issue_request(OP_COIN,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_RESEED,   32'h8000_0001, 32'h0,         32'h0,         32'h0);
    issue_request(OP_INTEGER,  32'h0,         32'h0,         32'h0,         32'h1);
    issue_request(OP_INTEGER,  32'h0,         32'h0,         32'hFFFF_FFFF, 32'h7FFF_FFFF);

    // Let the pipeline empty completely before the random part.
    in_valid <= 1'b0;
    wait_for_results();

    // Random part: mostly draws, with reseeds that often return the generator
    // to the unseeded state so the entropy path stays busy.
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      steady_tail = (n >= RANDOM_REQUESTS - STEADY_TAIL);
      if (n % 500 == 250) begin
        in_valid <= 1'b0;
        wait_for_results();
      end
      op   = ($urandom_range(0, 19) < 3) ? OP_RESEED : 2'($urandom_range(1, 3));
      seed = ($urandom_range(0, 3) == 0) ? 32'h0 : pick_signed_value();
      case ($urandom_range(0, 11))
        0:       ent = 32'h0000_0000;
        1:       ent = 32'h7FFF_FFFF;
        2:       ent = 32'hFFFF_FFFE;
        default: ent = $urandom();
      endcase
      ba = pick_signed_value();
      case ($urandom_range(0, 7))
        0:       bb = ba;
        1:       bb = ba + $urandom_range(1, 16);
        default: bb = pick_signed_value();
      endcase
      issue_request(op, seed, ent, ba, bb);
    end

    in_valid <= 1'b0;
    wait_for_results();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
